@@ src/pidpi_pkg.sv @@
`timescale 1ns / 1ps

package pidpi_pkg;

  // Field widths
  localparam int DataW    = 16;  // setpoint / measured
  localparam int GainW    = 16;  // kp, ki, kd (signed Q8.8)
  localparam int FracBits = 8;   // gain fraction bits
  localparam int LimW     = 24;  // integral clamp
  localparam int ErrW     = DataW + 1;  // setpoint - measured
  localparam int IntW     = LimW + 1;   // clamped integral, signed
  localparam int DriveW   = 32;

  // Multiplier operand widths (largest of the two modes)
  localparam int OpPW = ErrW + 1;  // e or e - last
  localparam int OpIW = IntW;      // integral or e
  localparam int OpDW = ErrW + 2;  // e - last or e - 2*last + prev

  // Product and accumulator widths
  localparam int ProdPW = GainW + OpPW;
  localparam int ProdIW = GainW + OpIW;
  localparam int ProdDW = GainW + OpDW;
  localparam int AccW   = ProdIW + 2;
  localparam int ShW    = AccW - FracBits;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = LimW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_LIMIT = 3'd3,
    CFG_MODE  = 3'd4
  } cfg_idx_e;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [LimW-1:0]         integral_limit;
    logic                    mode;
  } cfg_t;

  // Multiplier operands handed from the state stage to the MAC
  typedef struct packed {
    logic signed [OpPW-1:0] op_p;
    logic signed [OpIW-1:0] op_i;
    logic signed [OpDW-1:0] op_d;
  } op_t;

endpackage

@@ src/pidpi_cfg.sv @@
`timescale 1ns / 1ps

module pidpi_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pidpi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pidpi_pkg::CfgDataW-1:0]   cfg_data_i,
  output pidpi_pkg::cfg_t                  cfg_o
);
  import pidpi_pkg::*;

  cfg_t cfg_q;

  // Writes are always accepted
  assign cfg_ready_o = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp             <= '0;
      cfg_q.ki             <= '0;
      cfg_q.kd             <= '0;
      cfg_q.integral_limit <= '1;
      cfg_q.mode           <= MODE_POS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KP:    cfg_q.kp             <= $signed(cfg_data_i[GainW-1:0]);
        CFG_KI:    cfg_q.ki             <= $signed(cfg_data_i[GainW-1:0]);
        CFG_KD:    cfg_q.kd             <= $signed(cfg_data_i[GainW-1:0]);
        CFG_LIMIT: cfg_q.integral_limit <= cfg_data_i[LimW-1:0];
        CFG_MODE:  cfg_q.mode           <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/pidpi_state.sv @@
`timescale 1ns / 1ps

module pidpi_state (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidpi_pkg::cfg_t                   cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pidpi_pkg::DataW-1:0] setpoint_i,
  input  logic signed [pidpi_pkg::DataW-1:0] measured_i,
  input  logic                              motor_running_i,
  output logic                              op_valid_o,
  input  logic                              op_ready_i,
  output pidpi_pkg::op_t                    op_o
);
  import pidpi_pkg::*;

  logic                   a_v_q;
  logic signed [ErrW-1:0] a_err_q;
  logic                   a_run_q;
  logic                   b_v_q;
  op_t                    b_op_q;
  op_t                    b_op_d;

  logic signed [IntW-1:0] integral_q, integral_d;
  logic signed [ErrW-1:0] last_err_q;
  logic signed [ErrW-1:0] prev_err_q;

  logic signed [ErrW-1:0] err_in;
  logic signed [OpPW-1:0] diff1;
  logic signed [OpDW-1:0] diff2;
  logic signed [IntW:0]   sum_raw;
  logic signed [IntW:0]   sum_sel;
  logic signed [IntW:0]   lim_pos;
  logic signed [IntW:0]   lim_neg;
  logic                   rdy_a;
  logic                   rdy_b;

  // Stage ready chain, bubbles collapse
  assign rdy_b      = !b_v_q || op_ready_i;
  assign rdy_a      = !a_v_q || rdy_b;
  assign in_stall_o = !rdy_a;

  // Error of the incoming tick
  assign err_in = ErrW'(setpoint_i) - ErrW'(measured_i);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (rdy_a) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_err_q <= err_in;
      a_run_q <= motor_running_i;
    end
  end

  // Error differences
  assign diff1 = OpPW'(a_err_q) - OpPW'(last_err_q);
  assign diff2 = OpDW'(a_err_q) - (OpDW'(last_err_q) <<< 1) + OpDW'(prev_err_q);

  // Integral: add or clear, then clamp to +/- limit
  assign sum_raw = a_run_q ? ((IntW + 1)'(integral_q) + (IntW + 1)'(a_err_q)) : '0;
  assign lim_pos = $signed({2'b00, cfg_i.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum_raw > lim_pos) begin
      sum_sel = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_sel = lim_neg;
    end else begin
      sum_sel = sum_raw;
    end
  end

  // Integral only moves in positional mode
  assign integral_d = (cfg_i.mode == MODE_POS) ? sum_sel[IntW-1:0] : integral_q;

  // Operand select per mode
  always_comb begin
    if (cfg_i.mode == MODE_POS) begin
      b_op_d.op_p = OpPW'(a_err_q);
      b_op_d.op_i = integral_d;
      b_op_d.op_d = OpDW'(diff1);
    end else begin
      b_op_d.op_p = diff1;
      b_op_d.op_i = OpIW'(a_err_q);
      b_op_d.op_d = diff2;
    end
  end

  // Operand register and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q      <= 1'b0;
      integral_q <= '0;
      last_err_q <= '0;
      prev_err_q <= '0;
    end else if (rdy_b) begin
      b_v_q <= a_v_q;
      if (a_v_q) begin
        integral_q <= integral_d;
        last_err_q <= a_err_q;
        prev_err_q <= last_err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_v_q) begin
      b_op_q <= b_op_d;
    end
  end

  assign op_valid_o = b_v_q;
  assign op_o       = b_op_q;

endmodule

@@ src/pidpi_mac.sv @@
`timescale 1ns / 1ps

module pidpi_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pidpi_pkg::cfg_t                     cfg_i,
  input  logic                                op_valid_i,
  output logic                                op_ready_o,
  input  pidpi_pkg::op_t                      op_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidpi_pkg::DriveW-1:0] drive_o,
  output logic                                saturated_o
);
  import pidpi_pkg::*;

  logic                     c_v_q;
  logic signed [ProdPW-1:0] prod_p_q, prod_p_d;
  logic signed [ProdIW-1:0] prod_i_q, prod_i_d;
  logic signed [ProdDW-1:0] prod_d_q, prod_d_d;

  logic                     o_v_q;
  logic signed [DriveW-1:0] drive_q, drive_d;
  logic                     sat_q, sat_d;

  logic signed [AccW-1:0]   acc;
  logic signed [ShW-1:0]    shifted;
  logic                     rdy_o;
  logic                     rdy_c;

  assign rdy_o      = !o_v_q || !out_stall_i;
  assign rdy_c      = !c_v_q || rdy_o;
  assign op_ready_o = rdy_c;

  // Three gain multipliers
  assign prod_p_d = $signed(cfg_i.kp) * $signed(op_i.op_p);
  assign prod_i_d = $signed(cfg_i.ki) * $signed(op_i.op_i);
  assign prod_d_d = $signed(cfg_i.kd) * $signed(op_i.op_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (rdy_c) begin
      c_v_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && op_valid_i) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  // Sum, floor shift (drop fraction bits), saturate to 32 bits
  assign acc     = AccW'(prod_p_q) + AccW'(prod_i_q) + AccW'(prod_d_q);
  assign shifted = acc[AccW-1:FracBits];

  always_comb begin
    if ((&shifted[ShW-1:DriveW-1]) || !(|shifted[ShW-1:DriveW-1])) begin
      drive_d = shifted[DriveW-1:0];
      sat_d   = 1'b0;
    end else begin
      drive_d = shifted[ShW-1] ? {1'b1, {(DriveW - 1){1'b0}}} : {1'b0, {(DriveW - 1){1'b1}}};
      sat_d   = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (rdy_o) begin
      o_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && c_v_q) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

@@ src/pid_position_incremental.sv @@
`timescale 1ns / 1ps
// Pipeline: input register, operand register, product register, result register.
// Throughput: one item per cycle unless the output stalls; the error and integral update
// is done as the operand register loads, so back-to-back ticks follow without a bubble.
// The input side stalls only while the result register is full and stalled.
// Reset (async, active low): pipeline empty, gains zero, limit all ones,
// positional mode, integral and error history zero.

module pid_position_incremental (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidpi_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pidpi_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pidpi_pkg::DataW-1:0]  setpoint_i,
  input  logic signed [pidpi_pkg::DataW-1:0]  measured_i,
  input  logic                                motor_running_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidpi_pkg::DriveW-1:0] drive_o,
  output logic                                saturated_o
);
  import pidpi_pkg::*;

  cfg_t cfg;
  op_t  op;
  logic op_valid;
  logic op_ready;

  pidpi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pidpi_state u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .setpoint_i      (setpoint_i),
    .measured_i      (measured_i),
    .motor_running_i (motor_running_i),
    .op_valid_o      (op_valid),
    .op_ready_i      (op_ready),
    .op_o            (op)
  );

  pidpi_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ src/pidpi_checker.sv @@
`timescale 1ns / 1ps

module pidpi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pidpi_pkg::DriveW-1:0] drive_o,
  input logic                                saturated_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(drive_o) && $stable(saturated_o))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a full, stalled result register
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A clipped drive sits at one of the rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      drive_o == 32'sh7fffffff || drive_o == 32'sh80000000)
    else $error("saturated flag without rail value");

endmodule

bind pid_position_incremental pidpi_checker u_pidpi_checker (.*);
